>>> rtl/bucket_hash_table_overflow_chains_unit_macros.svh
// Assertion macros shared by the hash table unit; they sample on clk and idle in reset.
`ifndef BUCKET_HASH_TABLE_OVERFLOW_CHAINS_UNIT_MACROS_SVH
`define BUCKET_HASH_TABLE_OVERFLOW_CHAINS_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define HBT_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must hold whenever its trigger holds in the same cycle.
`define HBT_CHECK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define HBT_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hbt_pkg.sv
// Shared types and constants of the bucket hash table unit.
package hbt_pkg;

	localparam int KIND_W = 2;
	localparam int KEY_W  = 31;
	localparam int PAY_W  = 48;
	localparam int BC_W   = 5;
	localparam int STEP_W = $clog2(KEY_W);
	localparam int CNT_W  = 7;
	localparam int MAX_RES = 64;

	localparam logic [BC_W-1:0] BC_RESET = 5'd16;
	localparam logic [2:0] REG_BUCKET_COUNT = 3'd0;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2,
		OP_DUMP   = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_HEAD,
		S_HEADW,
		S_CHK,
		S_BLKW,
		S_SLOT,
		S_SLOTW,
		S_ADV,
		S_PUSH,
		S_DRD,
		S_DRW,
		S_ALLOC,
		S_LINK,
		S_CEND,
		S_FIN,
		S_RESP
	} bst_t;

endpackage

>>> rtl/hbt_front.sv
// Front end: accepts items and computes the bucket by a bit-serial remainder.
module hbt_front import hbt_pkg::*; #(
	parameter int BUCKETS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [KIND_W-1:0]        kind,
	input  logic [KEY_W-1:0]         key,
	input  logic [PAY_W-1:0]         payload,
	input  logic [BC_W-1:0]          bucket_count,
	input  logic                     q_full,
	output logic                     q_push,
	output logic [KIND_W+KEY_W+PAY_W+((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] q_wdata
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int CW = $clog2(BUCKETS + 1);
	localparam int EW = (CW > BC_W) ? CW : BC_W;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [EW-1:0]     rem_q;
	logic [KEY_W-1:0]  sh_q;
	logic [KEY_W-1:0]  key_q;
	logic [PAY_W-1:0]  pay_q;
	logic [KIND_W-1:0] kind_q;

	logic [EW-1:0]     div;
	logic [EW:0]       shifted;
	logic [EW-1:0]     rem_next;

	// Bucket count of zero acts as one, above the table size acts as the table size.
	always_comb begin
		if (bucket_count == '0) begin
			div = EW'(1);
		end else if (EW'(bucket_count) > EW'(BUCKETS)) begin
			div = EW'(BUCKETS);
		end else begin
			div = EW'(bucket_count);
		end
		shifted = {rem_q, sh_q[KEY_W-1]};
		if (shifted >= {1'b0, div}) begin
			rem_next = EW'(shifted - {1'b0, div});
		end else begin
			rem_next = shifted[EW-1:0];
		end
	end

	assign req_stall = busy_q;
	assign q_push    = busy_q && done_q && !q_full;
	assign q_wdata   = {kind_q, key_q, pay_q, rem_q[BW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			sh_q   <= '0;
			key_q  <= '0;
			pay_q  <= '0;
			kind_q <= '0;
		end else if (!busy_q) begin
			if (req_valid) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				step_q <= '0;
				rem_q  <= '0;
				sh_q   <= key;
				key_q  <= key;
				pay_q  <= payload;
				kind_q <= kind;
			end
		end else if (!done_q) begin
			rem_q  <= rem_next;
			sh_q   <= {sh_q[KEY_W-2:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(KEY_W - 1)) begin
				done_q <= 1'b1;
			end
		end else if (!q_full) begin
			busy_q <= 1'b0;
		end
	end

endmodule

>>> rtl/hbt_queue.sv
// Short first-in first-out queue between the front end and the table engine.
module hbt_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [NW-1:0] cnt_q;

	assign full  = (cnt_q == NW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if ((push && !full) && !(pop && !empty)) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (!(push && !full) && (pop && !empty)) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

>>> rtl/hbt_back.sv
// Table engine: walks bucket chains in the block memories and emits results.
`include "bucket_hash_table_overflow_chains_unit_macros.svh"
module hbt_back import hbt_pkg::*; #(
	parameter int BUCKETS           = 16,
	parameter int POOL_BLOCKS       = 16,
	parameter int RECORDS_PER_BLOCK = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  logic [KIND_W+KEY_W+PAY_W+((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] q_rdata,
	output logic              q_pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              status,
	output logic              found,
	output logic [KEY_W-1:0]  rec_key,
	output logic [PAY_W-1:0]  rec_payload,
	output logic              last
);

	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int LW    = $clog2(POOL_BLOCKS + 1);
	localparam int BKW   = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
	localparam int FW    = $clog2(RECORDS_PER_BLOCK + 1);
	localparam int IW    = (RECORDS_PER_BLOCK > 1) ? $clog2(RECORDS_PER_BLOCK) : 1;
	localparam int SLOTS = POOL_BLOCKS * RECORDS_PER_BLOCK;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW    = KEY_W + PAY_W;
	localparam logic [LW-1:0] NONE = LW'(POOL_BLOCKS);
	localparam logic [FW-1:0] RPB  = FW'(RECORDS_PER_BLOCK);

	// Memories.
	logic [LW-1:0] head_mem [BUCKETS];
	logic [FW-1:0] fill_mem [POOL_BLOCKS];
	logic [LW-1:0] next_mem [POOL_BLOCKS];
	logic [RW-1:0] slot_mem [SLOTS];

	logic [LW-1:0]  head_rd;
	logic [FW-1:0]  fill_rd;
	logic [LW-1:0]  next_rd;
	logic [RW-1:0]  slot_rd;

	logic           head_we;
	logic [BW-1:0]  head_waddr;
	logic [LW-1:0]  head_wdata;
	logic           fill_we;
	logic [BKW-1:0] fill_waddr;
	logic [FW-1:0]  fill_wdata;
	logic           next_we;
	logic [BKW-1:0] next_waddr;
	logic [LW-1:0]  next_wdata;
	logic           slot_we;
	logic [SW-1:0]  slot_waddr;
	logic [RW-1:0]  slot_wdata;
	logic [SW-1:0]  slot_raddr;

	// Control and item registers.
	bst_t           state_q;
	bst_t           state_d;
	op_t            kind_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [BW-1:0]  bkt_q;
	logic [BW-1:0]  clr_q;
	logic [LW-1:0]  cur_q;
	logic [LW-1:0]  nxt_q;
	logic [FW-1:0]  n_q;
	logic [IW-1:0]  i_q;
	logic [BKW-1:0] new_q;
	logic [LW-1:0]  used_q;
	logic           link_head_q;
	logic           status_q;
	logic [CNT_W-1:0] cnt_q;
	logic           pend_vld_q;
	logic [RW-1:0]  pend_q;
	logic [RW-1:0]  hold_q;

	logic           out_vld_q;
	logic           out_status_q;
	logic           out_found_q;
	logic [RW-1:0]  out_rec_q;
	logic           out_last_q;

	// Derived terms.
	logic           out_free;
	logic           out_load;
	logic [FW-1:0]  nf;
	logic           is_match;
	logic           can_take;
	logic           more_slots;
	logic           last_bucket;
	logic           pool_room;
	logic           cur_none;
	logic [SW-1:0]  cur_base;
	logic [SW-1:0]  used_base;
	logic [BKW-1:0] cur_blk;
	logic [BKW-1:0] used_blk;

	assign cur_blk     = cur_q[BKW-1:0];
	assign used_blk    = used_q[BKW-1:0];
	assign cur_base    = SW'(SW'(cur_blk) * SW'(RECORDS_PER_BLOCK));
	assign used_base   = SW'(SW'(used_blk) * SW'(RECORDS_PER_BLOCK));
	assign out_free    = !out_vld_q || !rsp_stall;
	assign nf          = (fill_rd > RPB) ? RPB : fill_rd;
	assign is_match    = (kind_q == OP_DUMP) || (slot_rd[RW-1:PAY_W] == key_q);
	assign can_take    = (cnt_q < CNT_W'(MAX_RES));
	assign more_slots  = (FW'(i_q) + FW'(1)) < n_q;
	assign last_bucket = (bkt_q == BW'(BUCKETS - 1));
	assign pool_room   = (used_q < NONE);
	assign cur_none    = (cur_q >= NONE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == BW'(BUCKETS - 1)) state_d = S_IDLE;
			S_IDLE:  if (!q_empty) state_d = S_HEAD;
			S_HEAD:  state_d = S_HEADW;
			S_HEADW: state_d = S_CHK;
			S_CHK: begin
				if (cur_none) begin
					state_d = (kind_q == OP_INSERT) ? S_ALLOC : S_CEND;
				end else begin
					state_d = S_BLKW;
				end
			end
			S_BLKW: begin
				if (kind_q == OP_INSERT) begin
					if (nf < RPB) begin
						state_d = S_RESP;
					end else if (next_rd >= NONE) begin
						state_d = S_ALLOC;
					end else begin
						state_d = S_CHK;
					end
				end else begin
					state_d = (nf != '0) ? S_SLOT : S_CHK;
				end
			end
			S_SLOT:  state_d = S_SLOTW;
			S_SLOTW: begin
				if (kind_q == OP_DELETE) begin
					state_d = is_match ? S_DRD : S_ADV;
				end else if (is_match && can_take && pend_vld_q) begin
					state_d = S_PUSH;
				end else begin
					state_d = S_ADV;
				end
			end
			S_PUSH:  if (out_free) state_d = S_ADV;
			S_ADV:   state_d = more_slots ? S_SLOT : S_CHK;
			S_DRD:   state_d = S_DRW;
			S_DRW:   state_d = S_CHK;
			S_ALLOC: state_d = (pool_room && !link_head_q) ? S_LINK : S_RESP;
			S_LINK:  state_d = S_RESP;
			S_CEND: begin
				if (kind_q == OP_DUMP && !last_bucket) begin
					state_d = S_HEAD;
				end else if (kind_q == OP_DELETE) begin
					state_d = S_RESP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN:   if (out_free) state_d = S_IDLE;
			S_RESP:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory controls and handshakes.
	always_comb begin
		q_pop      = 1'b0;
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = NONE;
		fill_we    = 1'b0;
		fill_waddr = cur_blk;
		fill_wdata = nf + FW'(1);
		next_we    = 1'b0;
		next_waddr = cur_blk;
		next_wdata = NONE;
		slot_we    = 1'b0;
		slot_waddr = cur_base + SW'(nf);
		slot_wdata = {key_q, pay_q};
		slot_raddr = cur_base + SW'(i_q);
		out_load   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
			end
			S_IDLE:  q_pop = !q_empty;
			S_BLKW: begin
				if (kind_q == OP_INSERT && nf < RPB) begin
					fill_we = 1'b1;
					slot_we = 1'b1;
				end
			end
			S_DRD:   slot_raddr = cur_base + SW'(n_q - FW'(1));
			S_DRW: begin
				fill_we    = 1'b1;
				fill_wdata = n_q - FW'(1);
				slot_we    = 1'b1;
				slot_waddr = cur_base + SW'(i_q);
				slot_wdata = slot_rd;
			end
			S_ALLOC: begin
				if (pool_room) begin
					fill_we    = 1'b1;
					fill_waddr = used_blk;
					fill_wdata = FW'(1);
					next_we    = 1'b1;
					next_waddr = used_blk;
					slot_we    = 1'b1;
					slot_waddr = used_base;
					head_we    = link_head_q;
					head_wdata = used_q;
				end
			end
			S_LINK: begin
				next_we    = 1'b1;
				next_wdata = LW'(new_q);
			end
			S_PUSH, S_FIN, S_RESP: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_waddr] <= head_wdata;
		head_rd <= head_mem[bkt_q];
	end

	always_ff @(posedge clk) begin
		if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
		if (next_we) next_mem[next_waddr] <= next_wdata;
		fill_rd <= fill_mem[cur_blk];
		next_rd <= next_mem[cur_blk];
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
		slot_rd <= slot_mem[slot_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			kind_q       <= OP_INSERT;
			key_q        <= '0;
			pay_q        <= '0;
			bkt_q        <= '0;
			clr_q        <= '0;
			cur_q        <= '0;
			nxt_q        <= '0;
			n_q          <= '0;
			i_q          <= '0;
			new_q        <= '0;
			used_q       <= '0;
			link_head_q  <= 1'b0;
			status_q     <= ST_OK;
			cnt_q        <= '0;
			pend_vld_q   <= 1'b0;
			pend_q       <= '0;
			hold_q       <= '0;
			out_vld_q    <= 1'b0;
			out_status_q <= ST_OK;
			out_found_q  <= 1'b0;
			out_rec_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLEAR: clr_q <= clr_q + BW'(1);
				S_IDLE: begin
					if (!q_empty) begin
						kind_q     <= op_t'(q_rdata[BW+RW +: KIND_W]);
						key_q      <= q_rdata[BW+PAY_W +: KEY_W];
						pay_q      <= q_rdata[BW +: PAY_W];
						bkt_q      <= (op_t'(q_rdata[BW+RW +: KIND_W]) == OP_DUMP) ?
						              '0 : q_rdata[BW-1:0];
						cnt_q      <= '0;
						status_q   <= ST_OK;
						pend_vld_q <= 1'b0;
					end
				end
				S_HEADW: begin
					cur_q       <= head_rd;
					link_head_q <= 1'b1;
				end
				S_BLKW: begin
					n_q         <= nf;
					nxt_q       <= next_rd;
					i_q         <= '0;
					link_head_q <= 1'b0;
					if (state_d == S_CHK) cur_q <= next_rd;
				end
				S_SLOTW: begin
					if (kind_q != OP_DELETE && is_match && can_take) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (pend_vld_q) begin
							hold_q <= slot_rd;
						end else begin
							pend_q     <= slot_rd;
							pend_vld_q <= 1'b1;
						end
					end
				end
				S_PUSH: if (out_free) pend_q <= hold_q;
				S_ADV: begin
					if (more_slots) begin
						i_q <= i_q + IW'(1);
					end else begin
						cur_q <= nxt_q;
					end
				end
				S_DRW: cur_q <= nxt_q;
				S_ALLOC: begin
					status_q <= pool_room ? ST_OK : ST_FULL;
					if (pool_room) begin
						new_q  <= used_blk;
						used_q <= used_q + LW'(1);
					end
				end
				S_CEND: if (kind_q == OP_DUMP && !last_bucket) bkt_q <= bkt_q + BW'(1);
				S_FIN: if (out_free) pend_vld_q <= 1'b0;
				default: ;
			endcase

			if (out_load) begin
				out_vld_q <= 1'b1;
				case (state_q)
					S_PUSH: begin
						out_status_q <= ST_OK;
						out_found_q  <= 1'b1;
						out_rec_q    <= pend_q;
						out_last_q   <= 1'b0;
					end
					S_FIN: begin
						out_status_q <= ST_OK;
						out_found_q  <= pend_vld_q;
						out_rec_q    <= pend_vld_q ? pend_q : '0;
						out_last_q   <= 1'b1;
					end
					default: begin
						out_status_q <= status_q;
						out_found_q  <= 1'b0;
						out_rec_q    <= '0;
						out_last_q   <= 1'b1;
					end
				endcase
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid   = out_vld_q;
	assign status      = out_status_q;
	assign found       = out_found_q;
	assign rec_key     = out_rec_q[RW-1:PAY_W];
	assign rec_payload = out_rec_q[PAY_W-1:0];
	assign last        = out_last_q;

	`HBT_CHECK(a_pool_bound, used_q <= NONE, "block pool count ran past the pool size")
	`HBT_CHECK_IMPL(a_idle_no_pend, state_q == S_IDLE, !pend_vld_q, "record left pending at idle")
	`HBT_CHECK_IMPL(a_push_has_pend, state_q == S_PUSH, pend_vld_q, "push without a pending record")
	`HBT_CHECK_NEXT(a_final_to_idle, out_load && (state_q == S_FIN || state_q == S_RESP), state_q == S_IDLE && out_last_q, "final result did not close the item")

endmodule

>>> rtl/bucket_hash_table_overflow_chains_unit.sv
// Top level of the bucket hash table unit with overflow chains.
// The front end takes each item through accept, 31 remainder steps and the queue push, which
// waits while the queue is full. The engine reads the bucket head and then each chain block,
// examines each record, moves a record when delete removes one, ends the chain, loads each
// result, waiting on output stalls. The front end takes no item until the last is pushed.
// Reset clears control state, then a pass over all buckets empties the bucket heads; no item
// is taken from the queue during that pass, while configuration writes are taken as ever.
module bucket_hash_table_overflow_chains_unit import hbt_pkg::*; #(
	parameter int BUCKETS           = 16,
	parameter int POOL_BLOCKS       = 16,
	parameter int RECORDS_PER_BLOCK = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// Item input channel.
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [KEY_W-1:0]  key,
	input  logic [PAY_W-1:0]  payload,
	// Result channel.
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              status,
	output logic              found,
	output logic [KEY_W-1:0]  rec_key,
	output logic [PAY_W-1:0]  rec_payload,
	output logic              last,
	// Configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int QW      = KIND_W + KEY_W + PAY_W + BW;
	localparam int Q_DEPTH = 2;

	logic [BC_W-1:0] bucket_count_q;
	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	logic [QW-1:0]   q_wdata;
	logic [QW-1:0]   q_rdata;

	// The bucket count register; software must write it only while the unit is idle, as the block does not enforce it.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_BUCKET_COUNT) ? {{(32 - BC_W){1'b0}}, bucket_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BC_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_BUCKET_COUNT) begin
			bucket_count_q <= pwdata[BC_W-1:0];
		end
	end

	// The front end reduces the key to a bucket number and hands the item over.
	hbt_front #(
		.BUCKETS (BUCKETS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.key          (key),
		.payload      (payload),
		.bucket_count (bucket_count_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_wdata      (q_wdata)
	);

	// Two classified items may wait here while the engine is busy.
	hbt_queue #(
		.W     (QW),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// The engine owns all table memories and the result register.
	hbt_back #(
		.BUCKETS           (BUCKETS),
		.POOL_BLOCKS       (POOL_BLOCKS),
		.RECORDS_PER_BLOCK (RECORDS_PER_BLOCK)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.found       (found),
		.rec_key     (rec_key),
		.rec_payload (rec_payload),
		.last        (last)
	);

endmodule

>>> bench/tb.sv
// Self-checking testbench of the bucket hash table unit with overflow chains.
module tb;
	import hbt_pkg::*;

	localparam int NB = 16;        // buckets
	localparam int NP = 16;        // pool blocks
	localparam int RPB = 4;        // records per block
	localparam int NONE = NP;      // empty link

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [KEY_W-1:0] key = '0;
	logic [PAY_W-1:0] payload = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic status, found, last;
	logic [KEY_W-1:0] rec_key;
	logic [PAY_W-1:0] rec_payload;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bucket_hash_table_overflow_chains_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.kind(kind), .key(key), .payload(payload),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .found(found), .rec_key(rec_key),
		.rec_payload(rec_payload), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// One result of the table as it should appear on the result port.
	typedef struct packed {
		logic st;
		logic fd;
		logic [KEY_W-1:0] k;
		logic [PAY_W-1:0] p;
		logic lst;
	} table_rsp_t;

	// A row of the directed table; chk marks rows whose single result is typed in.
	typedef struct {
		op_t op;
		logic [KEY_W-1:0] k;
		logic [PAY_W-1:0] p;
		bit chk;
		table_rsp_t want;
	} dir_row_t;

	// The mirror of the table contents that the predictor keeps.
	logic [4:0] mir_bc;
	int mir_head[NB];
	int mir_fill[NP];
	int mir_next[NP];
	logic [KEY_W-1:0] mir_key[NP*RPB];
	logic [PAY_W-1:0] mir_pay[NP*RPB];
	int mir_used;

	table_rsp_t pending_rsp[$];
	int errors = 0;
	bit rsp_busy = 1'b0;

	function automatic table_rsp_t mk(logic st, logic fd, logic [KEY_W-1:0] k,
			logic [PAY_W-1:0] p, logic lst);
		table_rsp_t r;
		r.st = st; r.fd = fd; r.k = k; r.p = p; r.lst = lst;
		return r;
	endfunction

	function automatic int grab_block(logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		int b;
		if (mir_used >= NP) return NONE;
		b = mir_used;
		mir_used++;
		mir_fill[b] = 1;
		mir_next[b] = NONE;
		mir_key[b*RPB] = k;
		mir_pay[b*RPB] = p;
		return b;
	endfunction

	// Returns 1 when the record found a home.
	function automatic bit table_insert(int bkt, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		int cur, b;
		cur = mir_head[bkt];
		if (cur >= NP) begin
			b = grab_block(k, p);
			if (b >= NP) return 1'b0;
			mir_head[bkt] = b;
			return 1'b1;
		end
		for (int s = 0; s < NP && cur < NP; s++) begin
			if (mir_fill[cur] < RPB) begin
				mir_key[cur*RPB + mir_fill[cur]] = k;
				mir_pay[cur*RPB + mir_fill[cur]] = p;
				mir_fill[cur]++;
				return 1'b1;
			end
			if (mir_next[cur] >= NP) begin
				b = grab_block(k, p);
				if (b >= NP) return 1'b0;
				mir_next[cur] = b;
				return 1'b1;
			end
			cur = mir_next[cur];
		end
		return 1'b0;
	endfunction

	function automatic void table_delete(int bkt, logic [KEY_W-1:0] k);
		int cur, n, base;
		cur = mir_head[bkt];
		for (int s = 0; s < NP && cur < NP; s++) begin
			n = mir_fill[cur];
			base = cur * RPB;
			for (int i = 0; i < n; i++) begin
				if (mir_key[base+i] == k) begin
					mir_key[base+i] = mir_key[base+n-1];
					mir_pay[base+i] = mir_pay[base+n-1];
					mir_fill[cur] = n - 1;
					break;
				end
			end
			cur = mir_next[cur];
		end
	endfunction

	function automatic void emit_chain(int bkt, bit every, logic [KEY_W-1:0] k,
			ref table_rsp_t rs[$]);
		int cur, base;
		cur = mir_head[bkt];
		for (int s = 0; s < NP && cur < NP; s++) begin
			base = cur * RPB;
			for (int i = 0; i < mir_fill[cur]; i++)
				if ((every || mir_key[base+i] == k) && rs.size() < MAX_RES)
					rs.push_back(mk(ST_OK, 1'b1, mir_key[base+i], mir_pay[base+i], 1'b0));
			cur = mir_next[cur];
		end
	endfunction

	// Applies one item to the mirror and queues the results it must produce.
	function automatic void predict_table(op_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		table_rsp_t rs[$];
		int nb, bkt;
		nb = (mir_bc == 0) ? 1 : (mir_bc > NB) ? NB : int'(mir_bc);
		bkt = int'(k % nb);
		case (op)
			OP_INSERT: begin
				rs.push_back(mk(table_insert(bkt, k, p) ? ST_OK : ST_FULL, 1'b0, '0, '0, 1'b1));
			end
			OP_DELETE: begin
				table_delete(bkt, k);
				rs.push_back(mk(ST_OK, 1'b0, '0, '0, 1'b1));
			end
			OP_LOOKUP: emit_chain(bkt, 1'b0, k, rs);
			default: for (int b = 0; b < NB; b++) emit_chain(b, 1'b1, '0, rs);
		endcase
		if (rs.size() == 0) rs.push_back(mk(ST_OK, 1'b0, '0, '0, 1'b1));
		rs[rs.size()-1].lst = 1'b1;
		foreach (rs[i]) pending_rsp.push_back(rs[i]);
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// The result side: random stalls, and each accepted result is checked against
	// the oldest expectation.
	always @(posedge clk) begin
		table_rsp_t w;
		bit stall_n;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("result with nothing expected: key %0d", rec_key);
					errors++;
				end else begin
					w = pending_rsp.pop_front();
					if (status !== w.st) begin
						$error("status: expected %0d, actual %0d", w.st, status); errors++;
					end
					if (found !== w.fd) begin
						$error("found: expected %0d, actual %0d", w.fd, found); errors++;
					end
					if (rec_key !== w.k) begin
						$error("rec_key: expected %0d, actual %0d", w.k, rec_key); errors++;
					end
					if (rec_payload !== w.p) begin
						$error("rec_payload: expected %0h, actual %0h", w.p, rec_payload);
						errors++;
					end
					if (last !== w.lst) begin
						$error("last: expected %0d, actual %0d", w.lst, last); errors++;
					end
				end
			end
			// Stall mostly briefly, now and then for a long stretch.
			stall_n = ($urandom_range(0, 99) < 30);
			if (rsp_busy) begin
				if ($urandom_range(0, 19) == 0) rsp_busy = 1'b0;
			end else if ($urandom_range(0, 199) == 0) begin
				rsp_busy = 1'b1;
			end
			if (rsp_busy) stall_n = 1'b1;
			rsp_stall <= stall_n;
		end
	end

	task automatic cfg_write(logic [4:0] v);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 3'(REG_BUCKET_COUNT) << 2; pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		mir_bc = v;
	endtask

	// Presents one item after a random gap and returns at its accepting edge with
	// valid still high; the next item or a drain takes valid down.
	task automatic drive_item(op_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		int g;
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1; kind <= op; key <= k; payload <= p;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send_item(op_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		drive_item(op, k, p);
		predict_table(op, k, p);
	endtask

	// Waits until every expected result has come, then lets the engine settle.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic run_phase(logic [4:0] bc, int n);
		logic [KEY_W-1:0] k;
		int r;
		cfg_write(bc);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			// Keys from a small set so that lookups and deletes hit, with some wide ones.
			if ($urandom_range(0, 3) == 0) k = KEY_W'($urandom);
			else k = KEY_W'($urandom_range(0, 40));
			if (r < 45) send_item(OP_INSERT, k, {$urandom, $urandom});
			else if (r < 75) send_item(OP_LOOKUP, k, {$urandom, $urandom});
			else if (r < 93) send_item(OP_DELETE, k, {$urandom, $urandom});
			else send_item(OP_DUMP, k, {$urandom, $urandom});
		end
		drain();
	endtask

	initial begin
		dir_row_t rows[$];
		table_rsp_t done_ok;
		done_ok = mk(ST_OK, 1'b0, '0, '0, 1'b1);
		for (int b = 0; b < NB; b++) mir_head[b] = NONE;
		mir_used = 0;
		mir_bc = BC_RESET;
		foreach (mir_fill[i]) begin mir_fill[i] = 0; mir_next[i] = 0; end
		foreach (mir_key[i]) begin mir_key[i] = '0; mir_pay[i] = '0; end

		// Directed table: the empty table, field extremes, a shared chain, delete
		// by moving the last record, and several matches of one key.
		rows = '{
			'{OP_DUMP,   31'd0,          48'd0,               1, done_ok},
			'{OP_LOOKUP, 31'h7FFFFFFF,   48'd0,               1, done_ok},
			'{OP_DELETE, 31'd5,          48'd0,               1, done_ok},
			'{OP_INSERT, 31'd0,          48'd0,               1, done_ok},
			'{OP_INSERT, 31'h7FFFFFFF,   48'hFFFFFFFFFFFF,    1, done_ok},
			'{OP_INSERT, 31'd16,         48'h123456789ABC,    1, done_ok},
			'{OP_INSERT, 31'd32,         48'h555555555555,    0, done_ok},
			'{OP_INSERT, 31'd48,         48'hAAAAAAAAAAAA,    0, done_ok},
			'{OP_INSERT, 31'd64,         48'd7,               0, done_ok},
			'{OP_INSERT, 31'd16,         48'd99,              0, done_ok},
			'{OP_LOOKUP, 31'd16,         48'd0,               0, done_ok},
			'{OP_LOOKUP, 31'h7FFFFFFF,   48'd0,               0, done_ok},
			'{OP_DUMP,   31'd0,          48'd0,               0, done_ok},
			'{OP_DELETE, 31'd16,         48'd0,               1, done_ok},
			'{OP_LOOKUP, 31'd16,         48'd0,               0, done_ok},
			'{OP_DELETE, 31'd0,          48'd0,               1, done_ok},
			'{OP_DUMP,   31'd0,          48'd0,               0, done_ok},
			'{OP_LOOKUP, 31'h2AAAAAAA,   48'hFFFFFFFFFFFF,    1, done_ok}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].chk) begin
				predict_table(rows[i].op, rows[i].k, rows[i].p);
				// The typed result takes the place of the mirror's last result; the port checks it.
				void'(pending_rsp.pop_back());
				pending_rsp.push_back(rows[i].want);
				drive_item(rows[i].op, rows[i].k, rows[i].p);
			end else begin
				send_item(rows[i].op, rows[i].k, rows[i].p);
			end
		end
		drain();

		// Random phases over several bucket counts, the extremes and out of range
		// among them; the later phases run the pool dry so that inserts report full.
		run_phase(5'd1, 50);
		run_phase(5'd16, 50);
		run_phase(5'd0, 30);
		run_phase(5'd7, 50);
		run_phase(5'd31, 40);
		run_phase(5'd3, 60);
		run_phase(5'd16, 80);

		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#300000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> bucket_hash_table_overflow_chains_unit.f
+incdir+rtl
rtl/hbt_pkg.sv
rtl/hbt_front.sv
rtl/hbt_queue.sv
rtl/hbt_back.sv
rtl/bucket_hash_table_overflow_chains_unit.sv
bench/tb.sv
